// ----- hw/rtl/hjrd_pkg.sv -----
package hjrd_pkg;

  typedef struct packed {
    logic       func;
    logic [5:0] position;
    logic [7:0] value;
    logic [5:0] button_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [27:0] joy_map;
    logic        changed;
    logic signed [7:0] analog_x;
    logic signed [7:0] analog_y;
  } out_item_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [2:0] REG_X_OFFSET    = 3'd0;
  localparam logic [2:0] REG_Y_OFFSET    = 3'd1;
  localparam logic [2:0] REG_WIDE_AXES   = 3'd2;
  localparam logic [2:0] REG_X_MIN       = 3'd3;
  localparam logic [2:0] REG_X_MAX       = 3'd4;
  localparam logic [2:0] REG_Y_MIN       = 3'd5;
  localparam logic [2:0] REG_Y_MAX       = 3'd6;
  localparam logic [2:0] REG_REPORT_LEN  = 3'd7;

  localparam logic [0:0] FUNC_BYTE  = 1'b0;
  localparam logic [0:0] FUNC_TABLE = 1'b1;

  localparam logic [15:0] THRESH_LOW  = 16'd64;
  localparam logic [15:0] THRESH_HIGH = 16'd192;
  localparam logic [15:0] FULL_SCALE  = 16'd255;
  localparam logic [15:0] CENTER      = 16'd128;

endpackage

// ----- hw/rtl/hid_joystick_report_decoder.sv -----
// Report bytes and table writes are taken only while idle. A closing byte that decodes
// offers its result once both axes and all buttons are done: each axis reads its low
// and high byte and is rescaled by the 26-step serial divider unless its range is an
// identity or zero range, each button goes through the table and report memories, and
// the map is built last. Throughput: one item per cycle while no decode or clearing
// pass runs; a decode blocks input until its result transfer. Reset (synchronous, rst
// high) clears the whole report memory; the button table has per-entry valid bits.
module hid_joystick_report_decoder #(
  parameter int unsigned REPORT_BYTES = 64,
  parameter int unsigned BUTTONS      = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  hjrd_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output hjrd_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [hjrd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hjrd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hjrd_pkg::*;

  localparam int unsigned AW = (REPORT_BYTES > 1) ? $clog2(REPORT_BYTES) : 1;
  localparam int unsigned BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  // Configuration registers.
  logic [5:0]  x_offset, y_offset;
  logic [1:0]  wide_axes;
  logic [15:0] x_min, x_max, y_min, y_max;
  logic [6:0]  report_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= 6'd0; y_offset <= 6'd1; wide_axes <= 2'd0;
      x_min <= 16'd0; x_max <= 16'd255; y_min <= 16'd0; y_max <= 16'd255;
      report_length <= 7'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_X_OFFSET:   x_offset <= cfg_wdata[5:0];
        REG_Y_OFFSET:   y_offset <= cfg_wdata[5:0];
        REG_WIDE_AXES:  wide_axes <= cfg_wdata[1:0];
        REG_X_MIN:      x_min <= cfg_wdata;
        REG_X_MAX:      x_max <= cfg_wdata;
        REG_Y_MIN:      y_min <= cfg_wdata;
        REG_Y_MAX:      y_max <= cfg_wdata;
        REG_REPORT_LEN: report_length <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer. Each axis: read lo byte, read hi byte, divide, then the buttons.
  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RD_LO = 11'b00000000100,
    S_RD_HI = 11'b00000001000,
    S_GRAB  = 11'b00000010000,
    S_DIV   = 11'b00000100000,
    S_BTN   = 11'b00001000000,
    S_BADR  = 11'b00010000000,
    S_BWAIT = 11'b00100000000,
    S_DONE  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;
  logic [AW-1:0] clr_addr;
  logic [6:0] bytes_seen;
  logic [27:0] previous_map, map_acc;
  logic axis_sel;          // 0 = x, 1 = y
  logic [15:0] raw, ax, ay;
  logic lo_ok, hi_ok;      // the addressed byte lies inside the store
  logic [BW-1:0] btn_idx;
  logic btn_ok;
  logic [4:0] div_cnt;

  // Report memory: one write port, one registered read port.
  logic [7:0] mem [REPORT_BYTES];
  logic [7:0] mem_q;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  logic in_fire;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (state == S_OUT);

  logic byte_in_store;
  assign byte_in_store = ({26'd0, in_data.position} < REPORT_BYTES);

  logic table_in_range;
  assign table_in_range = ({26'd0, in_data.position} < BUTTONS);

  // Button table memory, read at the current button index through a register.
  // Entries that were never written since reset read as zero through bvalid.
  logic [13:0] btab [BUTTONS];
  logic [13:0] btab_q;
  logic [BUTTONS-1:0] bvalid;
  logic btab_we;
  assign btab_we = in_fire && in_data.func == FUNC_TABLE && table_in_range;

  always_ff @(posedge clk) begin
    if (btab_we) btab[in_data.position[BW-1:0]] <= {in_data.button_byte, in_data.value};
    btab_q <= btab[btn_idx];
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = 8'd0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_fire && in_data.func == FUNC_BYTE && byte_in_store) begin
      mem_we = 1'b1;
      mem_wa = in_data.position[AW-1:0];
      mem_wd = in_data.value;
    end
  end

  // Axis byte address selection.
  logic [5:0] cur_off;
  logic [6:0] hi_pos;
  logic [13:0] cur_entry;
  assign cur_off = axis_sel ? y_offset : x_offset;
  assign hi_pos  = {1'b0, cur_off} + 7'd1;
  assign cur_entry = bvalid[btn_idx] ? btab_q : 14'd0;

  always_comb begin
    unique case (state)
      S_RD_LO: mem_ra = cur_off[AW-1:0];
      S_RD_HI: mem_ra = hi_pos[AW-1:0];
      default: mem_ra = cur_entry[8+AW-1:8];
    endcase
  end

  // Restoring divider on magnitudes: |num| up to 65535*255 fits 24 bits.
  logic [15:0] cur_min, cur_max;
  logic signed [17:0] diff_num, den_s;
  logic signed [26:0] num_s;
  logic [25:0] dvd;       // dividend magnitude shifting out
  logic [16:0] dvs;       // divisor magnitude
  logic [17:0] rem;
  logic [25:0] quo;
  logic q_neg;
  logic [18:0] rem_sh;
  logic [18:0] rem_sub;
  assign cur_min = axis_sel ? y_min : x_min;
  assign cur_max = axis_sel ? y_max : x_max;
  assign diff_num = $signed({2'b00, raw}) - $signed({2'b00, cur_min});
  assign den_s    = $signed({2'b00, cur_max}) - $signed({2'b00, cur_min});
  assign num_s    = (27'(diff_num) <<< 8) - 27'(diff_num);
  assign rem_sh  = {rem, dvd[25]};
  assign rem_sub = rem_sh - {2'b00, dvs};

  // An identity range passes the raw value through; a zero range gives zero.
  logic is_identity;
  logic [15:0] axis_res;
  logic [15:0] qv;
  assign is_identity = (cur_min == 16'd0 && cur_max == FULL_SCALE);
  assign axis_res = is_identity ? raw : 16'd0;
  assign qv = q_neg ? 16'(-quo) : quo[15:0];

  logic [15:0] cx, cy;
  assign cx = ax - CENTER;
  assign cy = ay - CENTER;

  // Byte count including the byte of the current transfer.
  logic [6:0] bytes_seen_next;
  logic enough;
  assign bytes_seen_next = (byte_in_store && bytes_seen < REPORT_BYTES) ?
                           bytes_seen + 7'd1 : bytes_seen;
  assign enough = bytes_seen_next >= report_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      bytes_seen <= 7'd0;
      previous_map <= 28'd0;
      bvalid <= '0;
      btn_idx <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if ({{(32-AW){1'b0}}, clr_addr} == REPORT_BYTES - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            if (in_data.func == FUNC_TABLE) begin
              if (table_in_range) bvalid[in_data.position[BW-1:0]] <= 1'b1;
            end else begin
              if (in_data.last) begin
                bytes_seen <= 7'd0;
                if (enough) begin
                  axis_sel <= 1'b0;
                  state <= S_RD_LO;
                end
              end else begin
                bytes_seen <= bytes_seen_next;
              end
            end
          end
        end
        S_RD_LO: begin
          lo_ok <= ({26'd0, cur_off} < REPORT_BYTES);
          hi_ok <= ({25'd0, hi_pos} < REPORT_BYTES);
          state <= S_RD_HI;
        end
        S_RD_HI: begin
          raw <= {8'd0, lo_ok ? mem_q : 8'd0};
          state <= S_GRAB;
        end
        S_GRAB: begin
          // mem_q now holds the high byte.
          if (wide_axes[axis_sel] && hi_ok) raw[15:8] <= mem_q;
          state <= S_DIV;
          div_cnt <= 5'd0;
        end
        S_DIV: begin
          if (div_cnt == 5'd0) begin
            if (is_identity || den_s == 18'sd0) begin
              if (axis_sel) ay <= axis_res; else ax <= axis_res;
              if (axis_sel) begin
                state <= S_BTN; btn_idx <= '0; map_acc <= 28'd0;
              end else begin
                axis_sel <= 1'b1; state <= S_RD_LO;
              end
            end else begin
              dvd <= num_s[26] ? 26'(-num_s) : num_s[25:0];
              dvs <= den_s[17] ? 17'(-den_s) : den_s[16:0];
              q_neg <= num_s[26] ^ den_s[17];
              rem <= 18'd0;
              quo <= 26'd0;
              div_cnt <= 5'd1;
            end
          end else if (div_cnt <= 5'd26) begin
            if (!rem_sub[18]) begin
              rem <= rem_sub[17:0]; quo <= {quo[24:0], 1'b1};
            end else begin
              rem <= rem_sh[17:0]; quo <= {quo[24:0], 1'b0};
            end
            dvd <= {dvd[24:0], 1'b0};
            div_cnt <= div_cnt + 5'd1;
          end else begin
            if (axis_sel) ay <= qv; else ax <= qv;
            if (axis_sel) begin
              state <= S_BTN; btn_idx <= '0; map_acc <= 28'd0;
            end else begin
              axis_sel <= 1'b1; state <= S_RD_LO;
            end
          end
        end
        S_BTN: begin
          // Table read for entry btn_idx is in flight this cycle.
          state <= S_BADR;
        end
        S_BADR: begin
          // The entry (zero if never written) is now available; the report byte it names is read this cycle.
          btn_ok <= ({26'd0, cur_entry[13:8]} < REPORT_BYTES);
          state <= S_BWAIT;
        end
        S_BWAIT: begin
          if (btn_ok && ((mem_q & cur_entry[7:0]) != 8'd0))
            map_acc[4 + btn_idx] <= 1'b1;
          if ({{(32-BW){1'b0}}, btn_idx} == BUTTONS - 1) state <= S_DONE;
          else begin
            btn_idx <= btn_idx + 1'b1;
            state <= S_BTN;
          end
        end
        S_DONE: begin
          out_data.joy_map <= {map_acc[27:4], ay < THRESH_LOW, ay > THRESH_HIGH,
                               ax < THRESH_LOW, ax > THRESH_HIGH};
          out_data.changed <= ({map_acc[27:4], ay < THRESH_LOW, ay > THRESH_HIGH,
                               ax < THRESH_LOW, ax > THRESH_HIGH} != previous_map);
          previous_map <= {map_acc[27:4], ay < THRESH_LOW, ay > THRESH_HIGH,
                               ax < THRESH_LOW, ax > THRESH_HIGH};
          out_data.analog_x <= cx[7:0];
          out_data.analog_y <= cy[7:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
